FILE: sv/bounded_set_with_range_lookup_core_defines.svh
// assertion helpers used by the core rtl file
`ifndef BOUNDED_SET_WITH_RANGE_LOOKUP_CORE_DEFINES_SVH
`define BOUNDED_SET_WITH_RANGE_LOOKUP_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BSRL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BSRL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/bsrl_pkg.sv
package bsrl_pkg;

    localparam int CAPACITY      = 16;
    localparam int PAGE_SHIFT    = 12;
    localparam int DATA_W        = 32;
    localparam int CNT_W         = $clog2(CAPACITY + 1);
    localparam int ENTRY_COUNT_W = 5;

    localparam logic [DATA_W-1:0] PAGE_MASK =
        DATA_W'((33'd1 << PAGE_SHIFT) - 33'd1);

    typedef logic [DATA_W-1:0]        t_data;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [ENTRY_COUNT_W-1:0] t_entry_count;

    typedef enum logic [3:0] {
        CMD_CLEAR        = 4'd0,
        CMD_ADD          = 4'd1,
        CMD_DELETE       = 4'd2,
        CMD_EXISTS       = 4'd3,
        CMD_WITHIN       = 4'd4,
        CMD_WITHIN_ROUND = 4'd5,
        CMD_GET_FIRST    = 4'd6,
        CMD_ITER_RESET   = 4'd7,
        CMD_ITER_GET     = 4'd8,
        CMD_ITER_ADVANCE = 4'd9
    } t_cmd;

    // request context broadcast to every cell during a scan
    typedef struct packed {
        logic [3:0] cmd;
        t_data      key;
        t_data      delta;
        t_cnt       count;
        t_cnt       iter_pos;
    } t_ctl;

    // set update applied to the cells at the end of a request
    typedef struct packed {
        logic  shift;
        logic  write;
        t_data key;
    } t_commit;

    // search token passed from cell to cell
    typedef struct packed {
        logic  valid;
        t_cnt  idx;
        logic  found;
        t_data value;
    } t_probe;

endpackage

FILE: sv/bounded_set_with_range_lookup_core.sv
// bounded set with range lookup
// keeps up to 16 distinct 32-bit values in insertion order in a row of cells
// s_axis carries one command request: clear, add, delete, exists, range test,
// page-rounded range test, get-first, iterator reset, get and advance
// m_axis returns exactly one result per request: hit, matched value,
// entry count after the command and overflow
// a request is taken only while the block is idle; a search token then walks
// the cell row one cell per cycle, so every scan takes the same time
// the scan time is set by the length of the cell row; the result then passes
// the capture register and the output register
// the result sits in an output register; a new request is accepted while it
// waits, and when the receiver stalls the finished search holds until the
// register frees, with the set update applied at that moment
// reset empties the set and rewinds the iterator; stored values are not
// cleared, they are simply outside the count
`include "bounded_set_with_range_lookup_core_defines.svh"

module bounded_set_with_range_lookup_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // command[3:0], key[35:4], delta[67:36], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // hit[0], matched_value[32:1], entry_count[37:33],
                                       // overflow[38], zero pad
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_inject;

    logic [3:0]      r_cmd;
    bsrl_pkg::t_data r_key;
    bsrl_pkg::t_data r_delta;
    bsrl_pkg::t_cnt  r_count, n_count;
    bsrl_pkg::t_cnt  r_iter,  n_iter;
    logic            r_fin_found;
    bsrl_pkg::t_data r_fin_value;

    logic                   r_out_valid;
    logic                   r_out_hit,   n_out_hit;
    bsrl_pkg::t_data        r_out_value, n_out_value;
    bsrl_pkg::t_entry_count r_out_count;
    logic                   r_out_ovf,   n_out_ovf;

    logic              w_accept;
    logic              w_out_free;
    logic              w_done;
    bsrl_pkg::t_ctl    w_ctl;
    bsrl_pkg::t_commit w_commit;
    bsrl_pkg::t_probe  w_probe [bsrl_pkg::CAPACITY+1];
    bsrl_pkg::t_data   w_entry [bsrl_pkg::CAPACITY];
    logic [bsrl_pkg::CAPACITY:0] w_probe_vld;

    assign s_axis_tready = r_state == S_IDLE;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_done        = (r_state == S_FINISH) && w_out_free;

    assign w_ctl = '{cmd: r_cmd, key: r_key, delta: r_delta,
                     count: r_count, iter_pos: r_iter};

    assign w_probe[0] = '{valid: r_inject, idx: '0, found: 1'b0, value: '0};

    for (genvar g = 0; g < bsrl_pkg::CAPACITY; g++) begin : g_cell
        bsrl_pkg::t_data w_next;
        if (g == bsrl_pkg::CAPACITY - 1) begin : g_last
            assign w_next = w_entry[g];
        end else begin : g_mid
            assign w_next = w_entry[g+1];
        end

        bsrl_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_commit     (w_commit),
            .i_probe      (w_probe[g]),
            .o_probe      (w_probe[g+1]),
            .i_next_entry (w_next),
            .o_entry      (w_entry[g])
        );
    end

    for (genvar v = 0; v <= bsrl_pkg::CAPACITY; v++) begin : g_vld
        assign w_probe_vld[v] = w_probe[v].valid;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_iter      = r_iter;
        n_out_hit   = 1'b0;
        n_out_value = '0;
        n_out_ovf   = 1'b0;
        w_commit    = '{shift: 1'b0, write: 1'b0, key: r_key};

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_probe[bsrl_pkg::CAPACITY].valid) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        case (r_cmd)
            bsrl_pkg::CMD_CLEAR: begin
                n_count = '0;
            end
            bsrl_pkg::CMD_ADD: begin
                if (r_fin_found) begin
                    n_out_hit   = 1'b1;
                    n_out_value = r_key;
                end else if (r_count == bsrl_pkg::CNT_W'(bsrl_pkg::CAPACITY)) begin
                    n_out_ovf = 1'b1;
                end else begin
                    w_commit.write = w_done;
                    n_count        = bsrl_pkg::CNT_W'(r_count + 1'b1);
                end
            end
            bsrl_pkg::CMD_DELETE: begin
                if (r_fin_found) begin
                    w_commit.shift = w_done;
                    n_count        = bsrl_pkg::CNT_W'(r_count - 1'b1);
                    n_out_hit      = 1'b1;
                    n_out_value    = r_key;
                end
            end
            bsrl_pkg::CMD_EXISTS, bsrl_pkg::CMD_WITHIN, bsrl_pkg::CMD_WITHIN_ROUND,
            bsrl_pkg::CMD_GET_FIRST, bsrl_pkg::CMD_ITER_GET: begin
                n_out_hit   = r_fin_found;
                n_out_value = r_fin_value;
            end
            bsrl_pkg::CMD_ITER_RESET: begin
                n_iter = '0;
            end
            bsrl_pkg::CMD_ITER_ADVANCE: begin
                if (r_iter != bsrl_pkg::CNT_W'(bsrl_pkg::CAPACITY)) begin
                    n_iter = bsrl_pkg::CNT_W'(r_iter + 1'b1);
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_inject    <= 1'b0;
            r_count     <= '0;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_inject <= w_accept;
            if (w_done) begin
                r_count     <= n_count;
                r_iter      <= n_iter;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= s_axis_tdata[3:0];
            r_key   <= s_axis_tdata[35:4];
            r_delta <= s_axis_tdata[67:36];
        end
        if ((r_state == S_SCAN) && w_probe[bsrl_pkg::CAPACITY].valid) begin
            r_fin_found <= w_probe[bsrl_pkg::CAPACITY].found;
            r_fin_value <= w_probe[bsrl_pkg::CAPACITY].value;
        end
        if (w_done) begin
            r_out_hit   <= n_out_hit;
            r_out_value <= n_out_value;
            r_out_count <= bsrl_pkg::t_entry_count'(n_count);
            r_out_ovf   <= n_out_ovf;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_ovf, r_out_count, r_out_value, r_out_hit};

    `BSRL_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= bsrl_pkg::CNT_W'(bsrl_pkg::CAPACITY), "entry count above capacity")
    `BSRL_ASSERT_NOW(a_one_token, i_clk, i_rst_n, 1'b1,
        $onehot0(w_probe_vld), "more than one search token in the cell row")
    `BSRL_ASSERT_NOW(a_token_walk, i_clk, i_rst_n, w_probe[bsrl_pkg::CAPACITY].valid,
        w_probe[bsrl_pkg::CAPACITY].idx == bsrl_pkg::CNT_W'(bsrl_pkg::CAPACITY),
        "token left the row without visiting every cell")
    `BSRL_ASSERT_NEXT(a_accept_scan, i_clk, i_rst_n, w_accept,
        (r_state == S_SCAN) && r_inject, "accepted request did not start a scan")
    `BSRL_ASSERT_NOW(a_ovf_no_hit, i_clk, i_rst_n, r_out_valid && r_out_ovf,
        !r_out_hit && (r_out_count == bsrl_pkg::t_entry_count'(bsrl_pkg::CAPACITY)),
        "overflow with a hit or below capacity")

endmodule

FILE: sv/bsrl_cell.sv
module bsrl_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bsrl_pkg::t_ctl    i_ctl,
    input  bsrl_pkg::t_commit i_commit,
    input  bsrl_pkg::t_probe  i_probe,
    output bsrl_pkg::t_probe  o_probe,
    input  bsrl_pkg::t_data   i_next_entry,
    output bsrl_pkg::t_data   o_entry
);

    bsrl_pkg::t_data r_entry;
    logic            r_vld;
    bsrl_pkg::t_cnt  r_idx;
    logic            r_found;
    bsrl_pkg::t_data r_value;
    logic            r_mark_del;
    logic            r_tail;

    logic            w_active;
    logic            w_match;
    bsrl_pkg::t_data w_sum;
    bsrl_pkg::t_data w_lo;
    bsrl_pkg::t_data w_hi;

    assign w_active = i_probe.idx < i_ctl.count;
    assign w_sum    = r_entry + i_ctl.delta;
    assign w_lo     = r_entry & ~bsrl_pkg::PAGE_MASK;
    assign w_hi     = (w_sum + bsrl_pkg::PAGE_MASK) & ~bsrl_pkg::PAGE_MASK;

    always_comb begin
        case (i_ctl.cmd)
            bsrl_pkg::CMD_ADD, bsrl_pkg::CMD_DELETE, bsrl_pkg::CMD_EXISTS: begin
                w_match = w_active && (r_entry == i_ctl.key);
            end
            bsrl_pkg::CMD_WITHIN: begin
                w_match = w_active && (i_ctl.key >= r_entry) && (i_ctl.key < w_sum);
            end
            bsrl_pkg::CMD_WITHIN_ROUND: begin
                w_match = w_active && (i_ctl.key >= w_lo) && (i_ctl.key < w_hi);
            end
            bsrl_pkg::CMD_GET_FIRST: begin
                w_match = w_active;
            end
            bsrl_pkg::CMD_ITER_GET: begin
                w_match = w_active && (i_probe.idx == i_ctl.iter_pos);
            end
            default: begin
                w_match = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_probe.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_probe.valid) begin
            r_idx      <= bsrl_pkg::CNT_W'(i_probe.idx + 1'b1);
            r_found    <= i_probe.found | w_match;
            r_value    <= i_probe.found ? i_probe.value : (w_match ? r_entry : '0);
            // at or after the first match: takes the neighbor on delete
            r_mark_del <= i_probe.found | w_match;
            // first free slot
            r_tail     <= i_probe.idx == i_ctl.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_commit.shift && r_mark_del) begin
            r_entry <= i_next_entry;
        end else if (i_commit.write && r_tail) begin
            r_entry <= i_commit.key;
        end
    end

    assign o_probe = '{valid: r_vld, idx: r_idx, found: r_found, value: r_value};
    assign o_entry = r_entry;

endmodule

FILE: tb/sv/tb_bounded_set_with_range_lookup_core.sv
`timescale 1ns / 1ps

module tb_bounded_set_with_range_lookup_core;

    localparam int               RANDOM_ITEMS   = 1850;
    localparam int               DRAIN_EVERY    = 300;
    localparam int               LATENCY        = bsrl_pkg::CAPACITY + 3;
    localparam int               TAIL_CYCLES    = 4 * LATENCY;
    localparam int               CYCLE_LIMIT    = 1000000;
    localparam logic [3:0]       CMD_UNUSED_LO  = 4'd10;
    localparam logic [3:0]       CMD_UNUSED_HI  = 4'd15;
    localparam bsrl_pkg::t_data  PAGE_SIZE      = bsrl_pkg::PAGE_MASK + 1;

    typedef struct {
        bsrl_pkg::t_data vals[bsrl_pkg::CAPACITY];
        int unsigned     cnt;
        int unsigned     iter;
    } t_set_state;

    typedef struct {
        logic [3:0]      cmd;
        bsrl_pkg::t_data key;
        bsrl_pkg::t_data delta;
        bit              drain_first;
        int              phase;
    } t_request;

    typedef struct {
        logic                   hit;
        bsrl_pkg::t_data        value;
        bsrl_pkg::t_entry_count count;
        logic                   ovf;
    } t_result;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata  = '0;  // command[3:0], key[35:4], delta[67:36], zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // hit[0], matched_value[32:1], entry_count[37:33],
                                      // overflow[38], zero pad

    t_request   pending_q[$];
    t_result    expected_q[$];
    t_request   cur_req;
    t_set_state dut_set;
    t_set_state gen_set;
    int         cur_phase      = 0;
    int         mismatch_count = 0;
    int         cycle_count    = 0;

    bounded_set_with_range_lookup_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned locate(input t_set_state st,
                                           input bsrl_pkg::t_data key);
        int unsigned idx;
        for (idx = 0; idx < st.cnt && idx < bsrl_pkg::CAPACITY; idx++) begin
            if (st.vals[idx] == key) begin
                return idx;
            end
        end
        return idx;
    endfunction

    function automatic t_result apply_command(inout t_set_state st, input logic [3:0] cmd,
                                              input bsrl_pkg::t_data key,
                                              input bsrl_pkg::t_data delta);
        t_result         res;
        int unsigned     pos;
        bsrl_pkg::t_data e;
        bsrl_pkg::t_data lo;
        bsrl_pkg::t_data hi;
        res = '{hit: 1'b0, value: '0, count: '0, ovf: 1'b0};
        case (cmd)
            bsrl_pkg::CMD_CLEAR: begin
                st.cnt = 0;
            end
            bsrl_pkg::CMD_ADD: begin
                pos = locate(st, key);
                if (pos < st.cnt) begin
                    res.hit = 1'b1;
                    res.value = key;
                end else if (st.cnt >= bsrl_pkg::CAPACITY) begin
                    res.ovf = 1'b1;
                end else begin
                    st.vals[st.cnt] = key;
                    st.cnt++;
                end
            end
            bsrl_pkg::CMD_DELETE: begin
                pos = locate(st, key);
                if (pos < st.cnt) begin
                    for (int j = pos; j + 1 < st.cnt; j++) begin
                        st.vals[j] = st.vals[j+1];
                    end
                    st.cnt--;
                    res.hit = 1'b1;
                    res.value = key;
                end
            end
            bsrl_pkg::CMD_EXISTS: begin
                if (locate(st, key) < st.cnt) begin
                    res.hit = 1'b1;
                    res.value = key;
                end
            end
            bsrl_pkg::CMD_WITHIN, bsrl_pkg::CMD_WITHIN_ROUND: begin
                for (int i = 0; i < st.cnt; i++) begin
                    e = st.vals[i];
                    if (cmd == bsrl_pkg::CMD_WITHIN) begin
                        lo = e;
                        hi = e + delta;
                    end else begin
                        lo = e & ~bsrl_pkg::PAGE_MASK;
                        hi = (e + delta + bsrl_pkg::PAGE_MASK) & ~bsrl_pkg::PAGE_MASK;
                    end
                    if (!res.hit && key >= lo && key < hi) begin
                        res.hit = 1'b1;
                        res.value = e;
                    end
                end
            end
            bsrl_pkg::CMD_GET_FIRST: begin
                if (st.cnt > 0) begin
                    res.hit = 1'b1;
                    res.value = st.vals[0];
                end
            end
            bsrl_pkg::CMD_ITER_RESET: begin
                st.iter = 0;
            end
            bsrl_pkg::CMD_ITER_GET: begin
                if (st.iter < st.cnt) begin
                    res.hit = 1'b1;
                    res.value = st.vals[st.iter];
                end
            end
            bsrl_pkg::CMD_ITER_ADVANCE: begin
                if (st.iter < bsrl_pkg::CAPACITY) begin
                    st.iter++;
                end
            end
            default: begin
            end
        endcase
        res.count = bsrl_pkg::t_entry_count'(st.cnt);
        return res;
    endfunction

    task automatic queue_request(input logic [3:0] cmd, input bsrl_pkg::t_data key,
                                 input bsrl_pkg::t_data delta,
                                 input bit drain_first, input int phase);
        t_result unused;
        pending_q.push_back('{cmd: cmd, key: key, delta: delta,
                              drain_first: drain_first, phase: phase});
        unused = apply_command(gen_set, cmd, key, delta);
    endtask

    function automatic bsrl_pkg::t_data fresh_value();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
            return bsrl_pkg::t_data'($urandom_range(0, 'h3FFFF));
        end else if (sel < 8) begin
            return bsrl_pkg::t_data'($urandom);
        end else if (sel < 9) begin
            return '1 - bsrl_pkg::t_data'($urandom_range(0, 4095));
        end
        return bsrl_pkg::t_data'($urandom) << bsrl_pkg::PAGE_SHIFT;
    endfunction

    function automatic bsrl_pkg::t_data random_delta();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
            return bsrl_pkg::t_data'($urandom_range(0, 255));
        end else if (sel < 6) begin
            return bsrl_pkg::t_data'($urandom_range(0, 'h2000));
        end else if (sel < 8) begin
            return bsrl_pkg::t_data'($urandom);
        end else if (sel < 9) begin
            return '0;
        end
        return '1 - bsrl_pkg::t_data'($urandom_range(0, 'h2000));
    endfunction

    function automatic bsrl_pkg::t_data stored_or_fresh(input int unsigned pct_stored);
        if (gen_set.cnt > 0 && $urandom_range(0, 99) < pct_stored) begin
            return gen_set.vals[$urandom_range(0, gen_set.cnt - 1)];
        end
        return fresh_value();
    endfunction

    function automatic int sender_idle_pct(input int phase);
        return phase == 0 ? 22 : (phase == 1 ? 84 : 0);
    endfunction

    function automatic int receiver_idle_pct(input int phase);
        return phase == 0 ? 84 : (phase == 1 ? 22 : 0);
    endfunction

    task automatic build_directed();
        queue_request(bsrl_pkg::CMD_ITER_GET,     32'h0,        32'h0,        1'b0, 0);
        queue_request(bsrl_pkg::CMD_GET_FIRST,    32'h0,        32'h0,        1'b0, 0);
        queue_request(bsrl_pkg::CMD_DELETE,       32'h0,        32'h0,        1'b0, 0);
        queue_request(bsrl_pkg::CMD_WITHIN,       32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 0);
        queue_request(bsrl_pkg::CMD_ADD,          32'h0,        32'h0,        1'b0, 0);
        queue_request(bsrl_pkg::CMD_ADD,          32'hFFFFFFFF, 32'h0,        1'b0, 0);
        queue_request(bsrl_pkg::CMD_ADD,          32'h00001000, 32'h0,        1'b0, 0);
        queue_request(bsrl_pkg::CMD_ADD,          32'h0,        32'h0,        1'b0, 0);
        queue_request(bsrl_pkg::CMD_EXISTS,       32'hFFFFFFFF, 32'h0,        1'b0, 0);
        queue_request(bsrl_pkg::CMD_WITHIN,       32'hFFFFFFFF, 32'h0,        1'b0, 0);
        queue_request(bsrl_pkg::CMD_WITHIN,       32'h0,        32'h1,        1'b0, 0);
        queue_request(bsrl_pkg::CMD_WITHIN,       32'h00001005, 32'h10,       1'b0, 0);
        queue_request(bsrl_pkg::CMD_WITHIN_ROUND, 32'h00001FFF, 32'h1,        1'b0, 0);
        queue_request(bsrl_pkg::CMD_WITHIN_ROUND, 32'h00002000, 32'hFFFFFFFF, 1'b0, 0);
        queue_request(bsrl_pkg::CMD_WITHIN_ROUND, 32'hFFFFF123, 32'h0,        1'b0, 0);
        queue_request(bsrl_pkg::CMD_ITER_ADVANCE, 32'h0,        32'h0,        1'b0, 0);
        queue_request(bsrl_pkg::CMD_ITER_GET,     32'h0,        32'h0,        1'b0, 0);
        queue_request(bsrl_pkg::CMD_DELETE,       32'h0,        32'h0,        1'b1, 0);
        queue_request(bsrl_pkg::CMD_ITER_GET,     32'h0,        32'h0,        1'b0, 0);
        queue_request(bsrl_pkg::CMD_GET_FIRST,    32'h0,        32'h0,        1'b0, 0);
        queue_request(bsrl_pkg::CMD_ITER_RESET,   32'h0,        32'h0,        1'b0, 0);
        queue_request(CMD_UNUSED_LO,              32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 0);
        queue_request(CMD_UNUSED_HI,              32'h0,        32'h0,        1'b0, 0);
        queue_request(bsrl_pkg::CMD_CLEAR,        32'h0,        32'h0,        1'b0, 0);
        queue_request(bsrl_pkg::CMD_ITER_GET,     32'h0,        32'h0,        1'b0, 0);
    endtask

    task automatic build_random();
        int unsigned     r;
        int              phase;
        bit              drain;
        bsrl_pkg::t_data key;
        bsrl_pkg::t_data delta;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            phase = (n * 3) / RANDOM_ITEMS;
            drain = (n % DRAIN_EVERY) == DRAIN_EVERY / 2;
            r = $urandom_range(0, 99);
            delta = random_delta();
            if (r < 30) begin
                queue_request(bsrl_pkg::CMD_ADD, stored_or_fresh(20), delta, drain, phase);
            end else if (r < 42) begin
                queue_request(bsrl_pkg::CMD_DELETE, stored_or_fresh(70), delta, drain, phase);
            end else if (r < 52) begin
                queue_request(bsrl_pkg::CMD_EXISTS, stored_or_fresh(60), delta, drain, phase);
            end else if (r < 64) begin
                key = stored_or_fresh(80);
                if ($urandom_range(0, 3) == 0) begin
                    key = key - bsrl_pkg::t_data'($urandom_range(1, 16));
                end else begin
                    key = key + bsrl_pkg::t_data'($urandom_range(0, 300));
                end
                queue_request(bsrl_pkg::CMD_WITHIN, key, delta, drain, phase);
            end else if (r < 74) begin
                key = (stored_or_fresh(80) & ~bsrl_pkg::PAGE_MASK) - PAGE_SIZE
                      + bsrl_pkg::t_data'($urandom_range(0, 3 * PAGE_SIZE));
                queue_request(bsrl_pkg::CMD_WITHIN_ROUND, key, delta, drain, phase);
            end else if (r < 78) begin
                queue_request(bsrl_pkg::CMD_GET_FIRST, bsrl_pkg::t_data'($urandom), delta,
                              drain, phase);
            end else if (r < 81) begin
                queue_request(bsrl_pkg::CMD_ITER_RESET, bsrl_pkg::t_data'($urandom), delta,
                              drain, phase);
            end else if (r < 88) begin
                queue_request(bsrl_pkg::CMD_ITER_GET, bsrl_pkg::t_data'($urandom), delta,
                              drain, phase);
            end else if (r < 93) begin
                queue_request(bsrl_pkg::CMD_ITER_ADVANCE, bsrl_pkg::t_data'($urandom), delta,
                              drain, phase);
            end else if (r < 95) begin
                queue_request(bsrl_pkg::CMD_CLEAR, bsrl_pkg::t_data'($urandom), delta,
                              drain, phase);
            end else if (r < 97) begin
                queue_request(4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)),
                              bsrl_pkg::t_data'($urandom), delta, drain, phase);
            end else begin
                queue_request(4'($urandom), bsrl_pkg::t_data'($urandom),
                              bsrl_pkg::t_data'($urandom), drain, phase);
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic check_result(input logic [39:0] d);
        t_result want;
        if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result %h with no request outstanding", d));
            return;
        end
        want = expected_q.pop_front();
        if (d[0] !== want.hit) begin
            report_mismatch($sformatf("hit %b, expected %b", d[0], want.hit));
        end
        if (d[32:1] !== want.value) begin
            report_mismatch($sformatf("matched_value %h, expected %h", d[32:1], want.value));
        end
        if (d[37:33] !== want.count) begin
            report_mismatch($sformatf("entry_count %0d, expected %0d", d[37:33], want.count));
        end
        if (d[38] !== want.ovf) begin
            report_mismatch($sformatf("overflow %b, expected %b", d[38], want.ovf));
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_q.push_back(apply_command(dut_set, cur_req.cmd, cur_req.key,
                                                   cur_req.delta));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_q.size() > 0
                        && $urandom_range(0, 99) >= sender_idle_pct(pending_q[0].phase)
                        && (!pending_q[0].drain_first || expected_q.size() == 0)) begin
                    cur_req = pending_q.pop_front();
                    cur_phase = cur_req.phase;
                    s_axis_tdata  <= {4'b0, cur_req.delta, cur_req.key, cur_req.cmd};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_result(m_axis_tdata);
            end
            m_axis_tready <= $urandom_range(0, 99) >= receiver_idle_pct(cur_phase);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("bounded_set_with_range_lookup_core verification failed");
            $finish;
        end
    end

    initial begin
        dut_set        = '{vals: '{default: '0}, cnt: 0, iter: 0};
        gen_set        = dut_set;
        build_directed();
        build_random();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_q.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_q.size() == 0) begin
            $display("bounded_set_with_range_lookup_core verification clean");
        end else begin
            $display("bounded_set_with_range_lookup_core verification failed");
        end
        $finish;
    end

endmodule
